// ===== hw/rtl/fspa_pkg.sv =====
// shared constants and types for the fixed slot pool allocator
`timescale 1ns / 1ps

package fspa_pkg;

    // configuration register widths and indexes
    localparam int OBJ_BYTES_W   = 13;
    localparam int SLOT_COUNT_W  = 9;
    localparam int CFG_ADDR_W    = 1;
    localparam int CFG_DATA_W    = 13;

    localparam logic [CFG_ADDR_W-1:0] REG_OBJECT_BYTES = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOT_COUNT   = 1'b1;

    localparam logic [OBJ_BYTES_W-1:0]  OBJ_BYTES_RESET  = 13'd16;
    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = 9'd256;
    localparam logic [OBJ_BYTES_W-1:0]  OBJ_BYTES_MIN    = 13'd4;
    localparam logic [OBJ_BYTES_W-1:0]  OBJ_BYTES_MAX    = 13'd4096;

    // payload widths
    localparam int OFFSET_W      = 20;   // signed word offset of a freed pointer
    localparam int DIV_W         = 19;   // magnitude bits of a non-negative offset
    localparam int SLOT_OFFSET_W = 18;   // word offset of an allocated slot
    localparam int STEP_W        = 11;   // slot size in words, 1 to 1024
    localparam int S_TDATA_W     = 24;
    localparam int S_TUSER_W     = 2;
    localparam int M_TDATA_W     = 24;
    localparam int M_TUSER_W     = 2;
    localparam int DIV_CNT_W     = 5;

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_INVALID = 2'd1;
    localparam status_t STATUS_ALREADY = 2'd2;
    localparam status_t STATUS_EMPTY   = 2'd3;

endpackage

// ===== hw/rtl/fixed_slot_pool_allocator_top.sv =====
// fixed slot pool allocator: free list of equal slots with validated and checked frees
`timescale 1ns / 1ps
//
//  channel   dir  handshake          content
//  s_        in   s_tvalid/s_tready  tuser: opcode, null_pointer; tdata: word_offset,
//                                    check_double_free
//  m_        out  m_tvalid/m_tready  tuser: status; tdata: slot_offset
//  cfg_      in   cfg_we             cfg_addr selects object_bytes or slot_count
//
//  allocate runs the head check and multiply, then the link read, then the result hand-off.
//  an unchecked free runs the 19-step divider, the alignment and range check and the push;
//  a checked free also walks the list links before the push, up to SLOTS of them.
//  after reset and after every config write the link store is rebuilt by a sweep over
//  all SLOTS entries, one entry per cycle; s_tready stays low during the sweep.
//  one item is in flight at a time; a stalled result holds in the output register.

module fixed_slot_pool_allocator_top #(
    parameter int SLOTS = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request beat
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fspa_pkg::S_TDATA_W-1:0]     s_tdata,  // [19:0] word_offset, [20] check_double_free
    input  logic [fspa_pkg::S_TUSER_W-1:0]     s_tuser,  // [0] opcode, [1] null_pointer
    // result beat
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fspa_pkg::M_TDATA_W-1:0]     m_tdata,  // [17:0] slot_offset
    output logic [fspa_pkg::M_TUSER_W-1:0]     m_tuser,  // [1:0] status
    // configuration writes
    input  logic                               cfg_we,
    input  logic [fspa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [fspa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import fspa_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam int PROD_W = IDX_W + STEP_W;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);

    typedef enum logic [8:0] {
        S_SWEEP = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_POP   = 9'b000000100,
        S_POPWB = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_JUDGE = 9'b000100000,
        S_WALK  = 9'b001000000,
        S_PUSH  = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [OBJ_BYTES_W-1:0]   obj_bytes_reg;
    logic [SLOT_COUNT_W-1:0]  slot_count_reg;
    logic [LINK_W-1:0]        head_reg, head_next;
    logic [IDX_W-1:0]         sweep_cnt_reg, sweep_cnt_next;
    logic [IDX_W-1:0]         walk_cnt_reg, walk_cnt_next;
    logic                     walk_first_reg, walk_first_next;
    logic [DIV_W-1:0]         quo_reg, quo_next;
    logic [STEP_W-1:0]        rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic                     check_reg, check_next;
    logic [LINK_W-1:0]        slot_reg, slot_next;
    status_t                  res_status_reg, res_status_next;
    logic [SLOT_OFFSET_W-1:0] res_offset_reg, res_offset_next;
    logic                     m_valid_reg, m_valid_next;
    status_t                  m_status_reg, m_status_next;
    logic [SLOT_OFFSET_W-1:0] m_offset_reg, m_offset_next;

    logic [OBJ_BYTES_W-1:0]   obj_clamp;
    logic [STEP_W-1:0]        step_words;
    logic [LINK_W-1:0]        n_slots;
    logic [LINK_W-1:0]        sweep_plus;
    logic [STEP_W-1:0]        trial;
    logic [PROD_W-1:0]        prod;
    logic [LINK_W-1:0]        walk_p;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [LINK_W-1:0]        ram_wdata;
    logic                     ram_re;
    logic [IDX_W-1:0]         ram_raddr;
    logic [LINK_W-1:0]        ram_rdata;

    // next-slot link store
    fspa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOTS)
    ) u_links (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // slot size in words and pool size from the config registers
    always_comb begin
        if (obj_bytes_reg < OBJ_BYTES_MIN) begin
            obj_clamp = OBJ_BYTES_MIN;
        end else if (obj_bytes_reg > OBJ_BYTES_MAX) begin
            obj_clamp = OBJ_BYTES_MAX;
        end else begin
            obj_clamp = obj_bytes_reg;
        end
        step_words = STEP_W'((obj_clamp + OBJ_BYTES_W'(3)) >> 2);

        if (slot_count_reg == '0) begin
            n_slots = LINK_W'(1);
        end else if (OBJ_BYTES_W'(slot_count_reg) > OBJ_BYTES_W'(SLOTS)) begin
            n_slots = NULL_LINK;
        end else begin
            n_slots = LINK_W'(slot_count_reg);
        end
    end

    // combinational datapath pieces
    assign sweep_plus = LINK_W'(sweep_cnt_reg) + LINK_W'(1);
    assign trial      = {rem_reg[STEP_W-2:0], quo_reg[DIV_W-1]};
    assign prod       = PROD_W'(head_reg[IDX_W-1:0]) * PROD_W'(step_words);
    assign walk_p     = walk_first_reg ? head_reg : ram_rdata;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        walk_cnt_next   = walk_cnt_reg;
        walk_first_next = walk_first_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        check_next      = check_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_offset_next   = m_offset_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        case (state_reg)
            // rebuild the list in ascending order
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = sweep_cnt_reg;
                ram_wdata = (sweep_plus < n_slots) ? sweep_plus : NULL_LINK;
                if (sweep_cnt_reg == LAST_IDX) begin
                    head_next  = '0;
                    state_next = S_IDLE;
                end else begin
                    sweep_cnt_next = sweep_cnt_reg + IDX_W'(1);
                end
            end
            // take a request and sort it
            S_IDLE: begin
                if (s_tvalid) begin
                    res_offset_next = '0;
                    if (s_tuser[0] == OP_ALLOC) begin
                        state_next = S_POP;
                    end else if (s_tuser[1] || s_tdata[OFFSET_W-1]) begin
                        res_status_next = STATUS_INVALID;
                        state_next      = S_RESP;
                    end else begin
                        quo_next     = s_tdata[DIV_W-1:0];
                        rem_next     = '0;
                        div_cnt_next = '0;
                        check_next   = s_tdata[OFFSET_W];
                        state_next   = S_DIV;
                    end
                end
            end
            // pop: read the head link and form the offset
            S_POP: begin
                if (head_reg >= NULL_LINK) begin
                    res_status_next = STATUS_EMPTY;
                    state_next      = S_RESP;
                end else begin
                    ram_re          = 1'b1;
                    ram_raddr       = head_reg[IDX_W-1:0];
                    res_offset_next = SLOT_OFFSET_W'(prod);
                    res_status_next = STATUS_OK;
                    state_next      = S_POPWB;
                end
            end
            S_POPWB: begin
                head_next  = ram_rdata;
                state_next = S_RESP;
            end
            // restoring divide, one quotient bit per cycle
            S_DIV: begin
                if (trial >= step_words) begin
                    rem_next = trial - step_words;
                    quo_next = {quo_reg[DIV_W-2:0], 1'b1};
                end else begin
                    rem_next = trial;
                    quo_next = {quo_reg[DIV_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    state_next = S_JUDGE;
                end
            end
            // alignment and range check on the slot number
            S_JUDGE: begin
                if (rem_reg != '0 || quo_reg >= DIV_W'(n_slots)) begin
                    res_status_next = STATUS_INVALID;
                    state_next      = S_RESP;
                end else begin
                    slot_next = LINK_W'(quo_reg);
                    if (check_reg) begin
                        walk_first_next = 1'b1;
                        walk_cnt_next   = '0;
                        state_next      = S_WALK;
                    end else begin
                        state_next = S_PUSH;
                    end
                end
            end
            // walk the free list, one link per cycle, bounded to SLOTS links
            S_WALK: begin
                if (walk_p >= NULL_LINK) begin
                    state_next = S_PUSH;
                end else if (walk_p == slot_reg) begin
                    res_status_next = STATUS_ALREADY;
                    state_next      = S_RESP;
                end else if (walk_cnt_reg == LAST_IDX) begin
                    state_next = S_PUSH;
                end else begin
                    ram_re          = 1'b1;
                    ram_raddr       = walk_p[IDX_W-1:0];
                    walk_cnt_next   = walk_cnt_reg + IDX_W'(1);
                    walk_first_next = 1'b0;
                end
            end
            // push the slot onto the head
            S_PUSH: begin
                ram_we          = 1'b1;
                ram_waddr       = slot_reg[IDX_W-1:0];
                ram_wdata       = head_reg;
                head_next       = slot_reg;
                res_status_next = STATUS_OK;
                state_next      = S_RESP;
            end
            // hand the result to the output register
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_offset_next = res_offset_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_SWEEP;
            end
        endcase

        // any config write restarts the rebuild
        if (cfg_we) begin
            state_next     = S_SWEEP;
            sweep_cnt_next = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_SWEEP;
            sweep_cnt_reg  <= '0;
            head_reg       <= '0;
            m_valid_reg    <= 1'b0;
            obj_bytes_reg  <= OBJ_BYTES_RESET;
            slot_count_reg <= SLOT_COUNT_RESET;
        end else begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            head_reg      <= head_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                if (cfg_addr == REG_OBJECT_BYTES) begin
                    obj_bytes_reg <= cfg_wdata;
                end else begin
                    slot_count_reg <= cfg_wdata[SLOT_COUNT_W-1:0];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        walk_cnt_reg   <= walk_cnt_next;
        walk_first_reg <= walk_first_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        div_cnt_reg    <= div_cnt_next;
        check_reg      <= check_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        m_status_reg   <= m_status_next;
        m_offset_reg   <= m_offset_next;
    end

    // ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_offset_reg);
    assign m_tuser  = m_status_reg;

    // one request at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in flight");

    // a config write always restarts the rebuild from entry zero
    a_cfg_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (state_reg == S_SWEEP && sweep_cnt_reg == '0))
        else $error("config write did not restart the rebuild");

    // only a slot inside the store is ever pushed
    a_push_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUSH) |-> (slot_reg < NULL_LINK))
        else $error("push of a slot outside the pool");

    // failed allocations and frees carry a zero offset
    a_zero_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg) && m_status_reg != STATUS_OK) |-> (m_offset_reg == '0))
        else $error("non-zero offset on a failed request");

endmodule

// ===== hw/rtl/fspa_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module fspa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== bench/fspa_alloc_checker.sv =====
// checker that mirrors the slot pool free list and compares every result beat
`timescale 1ns / 1ps

module fspa_alloc_checker #(
    parameter int SLOTS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fspa_pkg::S_TDATA_W-1:0]  s_tdata,   // [19:0] word_offset, [20] check_double_free
    input  logic [fspa_pkg::S_TUSER_W-1:0]  s_tuser,   // [0] opcode, [1] null_pointer
    // result channel
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fspa_pkg::M_TDATA_W-1:0]  m_tdata,   // [17:0] slot_offset
    input  logic [fspa_pkg::M_TUSER_W-1:0]  m_tuser,   // [1:0] status
    // configuration writes
    input  logic                            cfg_we,
    input  logic [fspa_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [fspa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // to the testbench top
    output int                              mismatches,
    output int                              pending
);

    import fspa_pkg::*;

    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

    typedef struct packed {
        status_t                  status;
        logic [SLOT_OFFSET_W-1:0] slot_offset;
    } alloc_result_t;

    // mirrored registers and free list
    logic [OBJ_BYTES_W-1:0]  obj_bytes;
    logic [SLOT_COUNT_W-1:0] slot_count;
    logic [LINK_W-1:0]       free_head;
    logic [LINK_W-1:0]       next_link [SLOTS];

    alloc_result_t expected_results [$];

    // slot size in words after clamping the object size
    function automatic logic [STEP_W-1:0] slot_words();
        logic [OBJ_BYTES_W-1:0] bytes_c;
        bytes_c = obj_bytes;
        if (bytes_c < OBJ_BYTES_MIN) bytes_c = OBJ_BYTES_MIN;
        if (bytes_c > OBJ_BYTES_MAX) bytes_c = OBJ_BYTES_MAX;
        return STEP_W'((bytes_c + 13'd3) >> 2);
    endfunction

    // usable slot count, clamped to 1..SLOTS
    function automatic int unsigned pool_size();
        if (slot_count == '0) return 1;
        if (slot_count > SLOTS) return SLOTS;
        return slot_count;
    endfunction

    // every slot free, ascending order
    function automatic void rebuild_pool();
        int unsigned n;
        n = pool_size();
        for (int i = 0; i < SLOTS; i++)
            next_link[i] = (i + 1 < n) ? LINK_W'(i + 1) : NULL_LINK;
        free_head = '0;
    endfunction

    // apply one request to the mirrored pool and return its result
    function automatic alloc_result_t serve_request(input logic op, input logic null_ptr,
                                                    input logic [OFFSET_W-1:0] offset,
                                                    input logic check);
        alloc_result_t res;
        int unsigned   step;
        int unsigned   n;
        int unsigned   slot;
        int unsigned   walk;
        logic [LINK_W-1:0] p;
        res.status      = STATUS_OK;
        res.slot_offset = '0;
        step = slot_words();
        n    = pool_size();
        if (op == OP_ALLOC) begin
            // pop the head, or report an empty pool
            if (free_head >= NULL_LINK) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.slot_offset = SLOT_OFFSET_W'(free_head * step);
                free_head       = next_link[free_head];
            end
        end else begin
            slot = offset / step;
            if (null_ptr || offset[OFFSET_W-1] || (offset % step) != 0 || slot >= n) begin
                res.status = STATUS_INVALID;
            end else begin
                // bounded walk looking for the slot among the free ones
                if (check) begin
                    p    = free_head;
                    walk = 0;
                    while (walk < SLOTS && p < NULL_LINK && res.status == STATUS_OK) begin
                        if (p == slot) res.status = STATUS_ALREADY;
                        else p = next_link[p];
                        walk++;
                    end
                end
                if (res.status == STATUS_OK) begin
                    next_link[slot] = free_head;
                    free_head       = LINK_W'(slot);
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got_v, want_v);
        mismatches++;
    endtask

    // watch the channels at each edge: config, result beats, then request beats
    always @(posedge aclk) begin
        alloc_result_t want;
        alloc_result_t got;
        if (!aresetn) begin
            obj_bytes  = OBJ_BYTES_RESET;
            slot_count = SLOT_COUNT_RESET;
            rebuild_pool();
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_OBJECT_BYTES) obj_bytes = cfg_wdata[OBJ_BYTES_W-1:0];
                else slot_count = cfg_wdata[SLOT_COUNT_W-1:0];
                rebuild_pool();
            end
            if (m_tvalid && m_tready) begin
                got.status      = m_tuser;
                got.slot_offset = m_tdata[SLOT_OFFSET_W-1:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with no request waiting, status",
                                    got.status, got.status);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.slot_offset != want.slot_offset)
                        report_mismatch("slot_offset", got.slot_offset, want.slot_offset);
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(serve_request(s_tuser[0], s_tuser[1],
                                                         s_tdata[OFFSET_W-1:0],
                                                         s_tdata[OFFSET_W]));
        end
        pending <= expected_results.size();
    end

endmodule

// ===== bench/tb_fixed_slot_pool_allocator_top.sv =====
// testbench top for the fixed slot pool allocator: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_fixed_slot_pool_allocator_top;

    import fspa_pkg::*;

    localparam int SLOTS           = 256;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_CYCLES     = 1500;
    localparam int DRAIN_CYCLES    = 300;
    localparam int STALL_LIMIT     = 20000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [19:0] word_offset, [20] check_double_free
    logic [S_TUSER_W-1:0]  s_tuser;   // [0] opcode, [1] null_pointer
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [17:0] slot_offset
    logic [M_TUSER_W-1:0]  m_tuser;   // [1:0] status
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int          mismatches;
    int          pending;
    int          gap_pct;
    int          stall_pct;
    bit          hold_pending;
    int unsigned req_step;
    int unsigned req_slots;
    int          stall_cycles;

    fixed_slot_pool_allocator_top #(
        .SLOTS(SLOTS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    fspa_alloc_checker #(
        .SLOTS(SLOTS)
    ) i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .mismatches(mismatches),
        .pending   (pending)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // one request beat, after a random sender gap
    task automatic send_request(input logic op, input logic nul,
                                input logic [OFFSET_W-1:0] off, input logic chk);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {nul, op};
        s_tdata  <= {(S_TDATA_W - OFFSET_W - 1)'(0), chk, off};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and wait until every result beat is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // write both registers and keep the clamped geometry for stimulus shaping
    task automatic set_pool(input int unsigned obj, input int unsigned cnt);
        int unsigned bytes_c;
        int unsigned cnt_c;
        write_reg(REG_OBJECT_BYTES, CFG_DATA_W'(obj));
        write_reg(REG_SLOT_COUNT, {(CFG_DATA_W - SLOT_COUNT_W)'($urandom),
                                   SLOT_COUNT_W'(cnt)});
        bytes_c   = obj % 8192;
        bytes_c   = (bytes_c < 4) ? 4 : (bytes_c > 4096) ? 4096 : bytes_c;
        req_step  = (bytes_c + 3) / 4;
        cnt_c     = cnt % 512;
        req_slots = (cnt_c == 0) ? 1 : (cnt_c > SLOTS) ? SLOTS : cnt_c;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_pending = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // cycles without any beat or register write
    initial begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int          alloc_pct;
        int unsigned slot;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        cfg_we       <= 1'b0;
        cfg_addr     <= REG_OBJECT_BYTES;
        cfg_wdata    <= '0;
        aresetn      <= 1'b0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_pending = 1'b0;
        req_step     = 4;
        req_slots    = SLOTS;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry: 4-word slots, full pool
        send_request(OP_ALLOC, 1'b0, 20'd0, 1'b0);
        send_request(OP_ALLOC, 1'b0, 20'd0, 1'b0);
        send_request(OP_FREE, 1'b0, 20'd0, 1'b1);
        send_request(OP_FREE, 1'b0, 20'd0, 1'b1);          // checked double free
        send_request(OP_FREE, 1'b1, 20'd4, 1'b1);          // null pointer
        send_request(OP_FREE, 1'b0, 20'hFFFFC, 1'b1);      // negative offset
        send_request(OP_FREE, 1'b0, 20'd1024, 1'b1);       // past the last slot
        send_request(OP_FREE, 1'b0, 20'd2, 1'b0);          // misaligned
        send_request(OP_FREE, 1'b0, 20'h7FFFF, 1'b1);
        send_request(OP_FREE, 1'b0, 20'h80000, 1'b0);
        send_request(OP_FREE, 1'b0, 20'd4, 1'b0);
        send_request(OP_ALLOC, 1'b1, 20'hA5A5A, 1'b1);     // allocate ignores the rest
        drain_results();

        // single slot pool, then empty pool
        set_pool(16, 1);
        send_request(OP_ALLOC, 1'b0, 20'd0, 1'b0);
        send_request(OP_ALLOC, 1'b0, 20'd0, 1'b0);
        send_request(OP_FREE, 1'b0, 20'd0, 1'b1);
        send_request(OP_FREE, 1'b0, 20'd0, 1'b1);
        drain_results();

        // zero object size; unchecked double free makes a cycle, then bounded walks
        set_pool(0, 4);
        send_request(OP_FREE, 1'b0, 20'd1, 1'b0);
        send_request(OP_FREE, 1'b0, 20'd2, 1'b1);
        send_request(OP_ALLOC, 1'b0, 20'd0, 1'b0);
        send_request(OP_FREE, 1'b0, 20'd3, 1'b1);
        drain_results();

        // oversized object, zero slot count
        set_pool(8191, 0);
        send_request(OP_ALLOC, 1'b0, 20'd0, 1'b0);
        send_request(OP_FREE, 1'b0, 20'd1024, 1'b1);
        send_request(OP_FREE, 1'b0, 20'd0, 1'b1);
        drain_results();

        // largest slot, slot count above the pool size
        set_pool(4096, 511);
        send_request(OP_ALLOC, 1'b0, 20'd0, 1'b0);
        send_request(OP_ALLOC, 1'b0, 20'd0, 1'b0);
        drain_results();

        // random phases, each with its own geometry and idling pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       set_pool(4, 8);
                1:       set_pool(4096, 256);
                2:       set_pool(1, 3);
                3:       set_pool(100, 16);
                4:       set_pool(13, 2);
                5:       set_pool(64, 32);
                6:       set_pool(8191, 1);
                7:       set_pool(2, 200);
                default: set_pool($urandom_range(8191), $urandom_range(24, 1));
            endcase
            gap_pct   = (ph % 4 == 1) ? 64 : (ph % 4 == 3) ? 8 : 0;
            stall_pct = (ph % 4 == 2) ? 64 : (ph % 4 == 3) ? 8 : 0;
            if (ph == 0) hold_pending = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // alternate allocate-heavy and free-heavy bursts
                alloc_pct = ((i / 20) % 2 == 0) ? 65 : 35;
                slot      = $urandom_range(req_slots - 1);
                if ($urandom_range(99) < alloc_pct) begin
                    send_request(OP_ALLOC, 1'($urandom), OFFSET_W'($urandom), 1'($urandom));
                end else if ($urandom_range(99) < 80) begin
                    send_request(OP_FREE, 1'b0, OFFSET_W'(slot * req_step),
                                 $urandom_range(99) < 85);
                end else begin
                    // malformed frees
                    case ($urandom_range(3))
                        0: send_request(OP_FREE, 1'($urandom), OFFSET_W'($urandom),
                                        1'($urandom));
                        1: send_request(OP_FREE, 1'b1, OFFSET_W'(slot * req_step),
                                        1'($urandom));
                        2: send_request(OP_FREE, 1'b0,
                                        OFFSET_W'(slot * req_step +
                                                  $urandom_range(req_step - 1)),
                                        1'($urandom));
                        default: send_request(OP_FREE, 1'b0,
                                              OFFSET_W'((req_slots + $urandom_range(3)) *
                                                        req_step),
                                              1'($urandom));
                    endcase
                end
            end
            drain_results();
        end

        // let the block settle, then the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== fixed_slot_pool_allocator_top.f =====
hw/rtl/fspa_pkg.sv
hw/rtl/fspa_ram.sv
hw/rtl/fixed_slot_pool_allocator_top.sv
bench/fspa_alloc_checker.sv
bench/tb_fixed_slot_pool_allocator_top.sv
